// ===== sv/bank_switch_mapper_with_irq_counter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Bank switch mapper core: assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BANK_SWITCH_MAPPER_WITH_IRQ_COUNTER_CORE_MACROS_SVH
`define BANK_SWITCH_MAPPER_WITH_IRQ_COUNTER_CORE_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define BSMIC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define BSMIC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bsmic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper core: package
// Payload types, register decode codes and IRQ unit command structure.
// ----------------------------------------------------------------------------
package bsmic_pkg;

   // Widths of the select-bit registers and of the configuration index.
   localparam int SelW    = 4;
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CSR_LOW_SEL  = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_HIGH_SEL = 1'b1;

   localparam int ChrRegs = 8;
   localparam int ChrIdxW = $clog2(ChrRegs);

   // Operations carried by an input item.
   localparam logic [2:0] OP_WRITE = 3'd0;
   localparam logic [2:0] OP_TICK  = 3'd1;
   localparam logic [2:0] OP_PRG   = 3'd2;
   localparam logic [2:0] OP_CHR   = 3'd3;
   localparam logic [2:0] OP_WRAM  = 3'd4;

   // Register groups selected by address bits 14:12.
   localparam logic [2:0] GRP_PRG0 = 3'd0;
   localparam logic [2:0] GRP_SND0 = 3'd1;
   localparam logic [2:0] GRP_SND1 = 3'd2;
   localparam logic [2:0] GRP_CTRL = 3'd3;
   localparam logic [2:0] GRP_PRG1 = 3'd4;
   localparam logic [2:0] GRP_CHR0 = 3'd5;
   localparam logic [2:0] GRP_CHR1 = 3'd6;
   localparam logic [2:0] GRP_IRQ  = 3'd7;

   // Register indexes within a group.
   localparam logic [1:0] IDX_RELOAD = 2'd0;
   localparam logic [1:0] IDX_MODE   = 2'd1;
   localparam logic [1:0] IDX_ACK    = 2'd2;
   localparam logic [1:0] IDX_CTRL   = 2'd3;

   // IRQ mode bits.
   localparam int MODE_REPEAT = 0;
   localparam int MODE_ENABLE = 1;
   localparam int MODE_CYCLE  = 2;

   localparam logic [7:0]        PRG1_RESET   = 8'hFE;
   localparam logic [8:0]        PRG_TOP_BANK = 9'h0FF;
   localparam logic signed [9:0] PRESC_RELOAD = 10'sd341;
   localparam logic signed [9:0] PRESC_STEP   = 10'sd3;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } req_type;

   typedef struct packed {
      logic [8:0] bank;
      logic       wram_enabled;
      logic [7:0] open_bus;
      logic [1:0] mirroring;
      logic       irq;
   } rsp_type;

   typedef struct packed {
      logic       tick;
      logic       wr_reload;
      logic       wr_mode;
      logic       ack;
      logic [7:0] data;
   } irq_cmd_type;

endpackage

// ===== sv/bsmic_irq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper core: IRQ counter
// Latch, mode, 8-bit counter, scanline prescaler and pending flag.
// ----------------------------------------------------------------------------
module bsmic_irq import bsmic_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  irq_cmd_type cmd,
   output logic        irq_next
);

   logic [7:0]        reload_ff, reload_in;
   logic [2:0]        mode_ff, mode_in;
   logic [7:0]        count_ff, count_in;
   logic signed [9:0] presc_ff, presc_in;
   logic              pending_ff, pending_in;
   logic signed [9:0] presc_dec;
   logic [7:0]        count_inc;
   logic              fire;

   always_comb begin
      reload_in  = reload_ff;
      mode_in    = mode_ff;
      count_in   = count_ff;
      presc_in   = presc_ff;
      pending_in = pending_ff;
      presc_dec  = presc_ff - PRESC_STEP;
      count_inc  = count_ff + 8'd1;
      fire       = 1'b0;

      if (cmd.wr_reload) begin
         reload_in = cmd.data;
      end
      if (cmd.wr_mode) begin
         mode_in    = cmd.data[2:0];
         pending_in = 1'b0;
         if (cmd.data[MODE_ENABLE]) begin
            count_in = reload_ff;
            presc_in = PRESC_RELOAD;
         end
      end
      if (cmd.ack) begin
         mode_in    = {mode_ff[MODE_CYCLE], mode_ff[MODE_REPEAT], mode_ff[MODE_REPEAT]};
         pending_in = 1'b0;
      end
      if (cmd.tick && mode_ff[MODE_ENABLE]) begin
         if (mode_ff[MODE_CYCLE]) begin
            fire = 1'b1;
         end else begin
            fire     = (presc_dec <= 10'sd0);
            presc_in = fire ? presc_dec + PRESC_RELOAD : presc_dec;
         end
         if (fire) begin
            if (count_inc == 8'd0) begin
               count_in   = reload_ff;
               pending_in = 1'b1;
            end else begin
               count_in = count_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff  <= '0;
         mode_ff    <= '0;
         count_ff   <= '0;
         presc_ff   <= '0;
         pending_ff <= 1'b0;
      end else begin
         reload_ff  <= reload_in;
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         presc_ff   <= presc_in;
         pending_ff <= pending_in;
      end
   end

   assign irq_next = pending_in;

endmodule

// ===== sv/bank_switch_mapper_with_irq_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper core with IRQ counter
// Cartridge mapper: register writes, CPU ticks, PRG/CHR lookups, work-RAM checks.
// ----------------------------------------------------------------------------
// The core takes one item per clock while the result side is not stalled and
// returns exactly one result item for each. An item is first captured in an
// input register; once the result register can take it, a single pass of logic
// decodes it, updates the bank, control and IRQ registers and writes the result
// register. Because all mapper state changes in that one pass, the following
// item already sees the updated state, so consecutive items never wait on each
// other. The result register frees the input side: a new item is taken into an
// empty input register while a finished result still waits to be collected.
// The two select-bit registers are written through the csr port, which is
// always ready; they should only be changed while no item is in flight.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_irq_counter_core import bsmic_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [SelW-1:0]    csr_wdata
);

   // Pipeline registers.
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff, out_data_in;
   logic    advance;
   logic    in_go;

   // Mapper state.
   logic [SelW-1:0] low_sel_ff;
   logic [SelW-1:0] high_sel_ff;
   logic [7:0]      prg_banks_ff [2];
   logic [7:0]      chr_banks_ff [ChrRegs];
   logic [7:0]      control_ff, control_in;

   // Decode of the item held in the input register.
   logic [1:0]         sel_idx;
   logic [2:0]         group;
   logic               is_write;
   logic               prg_wr;
   logic               chr_wr;
   logic [ChrIdxW-1:0] chr_wr_idx;
   irq_cmd_type        irq_cmd;
   logic               irq_next;

   // The result register accepts a new item when empty or being emptied; the
   // input register moves on under the same condition.
   assign advance   = !out_valid_ff || rsp_ready;
   assign in_go     = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Register index bits come from two configurable address positions; when
   // both point at the same bit, both index bits copy it.
   assign sel_idx    = {in_data_ff.addr[high_sel_ff], in_data_ff.addr[low_sel_ff]};
   assign group      = in_data_ff.addr[14:12];
   assign is_write   = in_go && (in_data_ff.op == OP_WRITE);
   assign chr_wr_idx = {in_data_ff.addr[13], sel_idx};

   always_comb begin
      prg_wr            = 1'b0;
      chr_wr            = 1'b0;
      control_in        = control_ff;
      irq_cmd.tick      = in_go && (in_data_ff.op == OP_TICK);
      irq_cmd.wr_reload = 1'b0;
      irq_cmd.wr_mode   = 1'b0;
      irq_cmd.ack       = 1'b0;
      irq_cmd.data      = in_data_ff.wdata;
      if (is_write) begin
         unique case (group) inside
            GRP_PRG0, GRP_PRG1: begin
               prg_wr = 1'b1;
            end
            GRP_CTRL: begin
               if (sel_idx == IDX_CTRL) begin
                  control_in = in_data_ff.wdata;
               end
            end
            GRP_CHR0, GRP_CHR1: begin
               chr_wr = 1'b1;
            end
            GRP_IRQ: begin
               irq_cmd.wr_reload = (sel_idx == IDX_RELOAD);
               irq_cmd.wr_mode   = (sel_idx == IDX_MODE);
               irq_cmd.ack       = (sel_idx == IDX_ACK);
            end
            // Sound registers have no effect on the mapper.
            GRP_SND0, GRP_SND1: begin
            end
         endcase
      end
   end

   bsmic_irq u_irq (
      .clock    (clock),
      .reset    (reset),
      .cmd      (irq_cmd),
      .irq_next (irq_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_banks_ff[0] <= '0;
         prg_banks_ff[1] <= PRG1_RESET;
         for (int i = 0; i < ChrRegs; i++) begin
            chr_banks_ff[i] <= 8'(i);
         end
         control_ff  <= '0;
         low_sel_ff  <= SelW'(0);
         high_sel_ff <= SelW'(1);
      end else begin
         if (prg_wr) begin
            prg_banks_ff[in_data_ff.addr[14]] <= in_data_ff.wdata;
         end
         if (chr_wr) begin
            chr_banks_ff[chr_wr_idx] <= in_data_ff.wdata;
         end
         control_ff <= control_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOW_SEL:  low_sel_ff  <= csr_wdata;
               CSR_HIGH_SEL: high_sel_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Result of the item, formed against the state as it stands after the item.
   always_comb begin
      out_data_in.bank         = '0;
      out_data_in.open_bus     = '0;
      out_data_in.wram_enabled = control_in[7];
      out_data_in.mirroring    = control_in[3:2];
      out_data_in.irq          = irq_next;
      case (in_data_ff.op)
         OP_PRG: begin
            // Address bit 15 is ignored, so the slot is bits 14:13.
            case (in_data_ff.addr[14:13])
               2'd0:    out_data_in.bank = {prg_banks_ff[0], 1'b0};
               2'd1:    out_data_in.bank = {prg_banks_ff[0], 1'b1};
               2'd2:    out_data_in.bank = {1'b0, prg_banks_ff[1]};
               default: out_data_in.bank = PRG_TOP_BANK;
            endcase
         end
         OP_CHR: begin
            out_data_in.bank = {1'b0, chr_banks_ff[in_data_ff.addr[12:10]]};
         end
         OP_WRAM: begin
            out_data_in.open_bus = in_data_ff.addr[15:8];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_go) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== sv/bsmic_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper core: port checker
// Concurrent checks on the result port, bound to the top level.
// ----------------------------------------------------------------------------
`include "bank_switch_mapper_with_irq_counter_core_macros.svh"

module bsmic_checker import bsmic_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result stays offered and unchanged.
   `BSMIC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // No result is offered in the cycle after reset has been seen.
   `BSMIC_ASSERT_NXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid, "result offered after reset")

   // An open-bus byte only comes from a work-RAM check, which maps no bank.
   `BSMIC_ASSERT_IMP(a_obus_bank, clock, reset, rsp_valid && (rsp_data.open_bus != 8'd0), rsp_data.bank == 9'd0, "bank and open bus both set")

endmodule

bind bank_switch_mapper_with_irq_counter_core bsmic_checker u_checker (.*);

// ===== test/tb_bank_switch_mapper_with_irq_counter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switch mapper core: self-checking testbench
// Drives register writes, CPU ticks, PRG/CHR lookups and work-RAM checks into
// the core, mirrors the mapper and IRQ counter state in a local predictor and
// compares every result item, field by field, against the predicted one.
// ----------------------------------------------------------------------------
module tb_bank_switch_mapper_with_irq_counter_core;
   import bsmic_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 4;
   localparam int PHASES         = 5;
   localparam int ITEMS_PER_SET  = 260;
   localparam int REPORT_LIMIT   = 10;
   // Nothing legitimate keeps every channel quiet for long, so this is many
   // times the worst case.
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [SelW-1:0]     csr_wdata = '0;

   // Items waiting to be sent, and the results the mapper should give back.
   req_type access_q[$];
   rsp_type predicted_results[$];

   int  items_queued   = 0;
   int  items_taken    = 0;
   int  results_seen   = 0;
   int  fault_count    = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   int  stalled_cycles = 0;
   bit  steady         = 1'b0;
   rsp_type want_rsp;

   // Local copy of the mapper state and of the select-bit registers.
   logic [7:0] prg_bank_q [2];
   logic [7:0] chr_bank_q [ChrRegs];
   logic [7:0] ctrl_q;
   logic [7:0] irq_latch_q;
   logic [7:0] irq_mode_q;
   logic [7:0] irq_counter_q;
   int         prescale_q;
   logic       irq_flag_q;
   logic [SelW-1:0] sel_lo = 4'd0;
   logic [SelW-1:0] sel_hi = 4'd1;

   bank_switch_mapper_with_irq_counter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // Puts the mapper copy back into its state after reset.
   function automatic void clear_mapper();
      prg_bank_q[0] = '0;
      prg_bank_q[1] = PRG1_RESET;
      for (int i = 0; i < ChrRegs; i++) begin
         chr_bank_q[i] = 8'(i);
      end
      ctrl_q        = '0;
      irq_latch_q   = '0;
      irq_mode_q    = '0;
      irq_counter_q = '0;
      prescale_q    = 0;
      irq_flag_q    = 1'b0;
      sel_lo        = 4'd0;
      sel_hi        = 4'd1;
   endfunction

   // Applies one item to the mapper copy and returns the result it gives.
   function automatic rsp_type map_access(input req_type it);
      rsp_type    r;
      logic [1:0] idx;
      logic [1:0] slot;
      bit         fire;
      r    = '0;
      idx  = {it.addr[sel_hi], it.addr[sel_lo]};
      slot = it.addr[14:13];
      case (it.op)
         OP_WRITE: begin
            // A15 plays no part in the decode; bits 14:12 pick the group.
            case (it.addr[14:12])
               GRP_PRG0, GRP_PRG1: prg_bank_q[it.addr[14]] = it.wdata;
               GRP_CTRL: begin
                  if (idx == IDX_CTRL) ctrl_q = it.wdata;
               end
               GRP_CHR0, GRP_CHR1: chr_bank_q[{it.addr[13], idx}] = it.wdata;
               GRP_IRQ: begin
                  if (idx == IDX_RELOAD) begin
                     irq_latch_q = it.wdata;
                  end else if (idx == IDX_MODE) begin
                     irq_mode_q = it.wdata;
                     if (irq_mode_q[MODE_ENABLE]) begin
                        irq_counter_q = irq_latch_q;
                        prescale_q    = int'(PRESC_RELOAD);
                     end
                     irq_flag_q = 1'b0;
                  end else if (idx == IDX_ACK) begin
                     irq_mode_q[MODE_ENABLE] = irq_mode_q[MODE_REPEAT];
                     irq_flag_q = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         OP_PRG: begin
            if (slot[1]) r.bank = slot[0] ? PRG_TOP_BANK : {1'b0, prg_bank_q[1]};
            else         r.bank = {prg_bank_q[0], slot[0]};
         end
         OP_CHR:  r.bank = {1'b0, chr_bank_q[it.addr[12:10]]};
         OP_WRAM: r.open_bus = it.addr[15:8];
         OP_TICK: begin
            if (irq_mode_q[MODE_ENABLE]) begin
               if (irq_mode_q[MODE_CYCLE]) begin
                  fire = 1'b1;
               end else begin
                  prescale_q = prescale_q - int'(PRESC_STEP);
                  fire       = (prescale_q <= 0);
               end
               if (fire) begin
                  if (!irq_mode_q[MODE_CYCLE]) prescale_q = prescale_q + int'(PRESC_RELOAD);
                  irq_counter_q = irq_counter_q + 8'd1;
                  if (irq_counter_q == 8'd0) begin
                     irq_counter_q = irq_latch_q;
                     irq_flag_q    = 1'b1;
                  end
               end
            end
         end
         default: ;   // spare opcodes leave the state alone
      endcase
      r.wram_enabled = ctrl_q[7];
      r.mirroring    = ctrl_q[3:2];
      r.irq          = irq_flag_q;
      return r;
   endfunction

   task automatic note_fault(input string what);
      if (fault_count < REPORT_LIMIT) $display("mismatch: %s", what);
      fault_count++;
   endtask

   task automatic check_field(input string field, input logic [8:0] got,
                              input logic [8:0] want);
      if (got !== want) begin
         note_fault($sformatf("result %0d %s expected 0x%0h got 0x%0h",
                              results_seen, field, want, got));
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic void queue_access(input logic [2:0] op, input logic [15:0] addr,
                                        input logic [7:0] wdata);
      req_type it;
      it.op    = op;
      it.addr  = addr;
      it.wdata = wdata;
      access_q.push_back(it);
      items_queued++;
   endfunction

   // Builds a register address for the given group and index under the
   // current select bits. Where a select bit lands on a group bit the group
   // changes, which is legal traffic in its own right.
   function automatic logic [15:0] reg_addr(input logic [2:0] group, input logic [1:0] idx);
      logic [15:0] a;
      a          = 16'($urandom);
      a[14:12]   = group;
      a[sel_hi]  = idx[1];
      a[sel_lo]  = idx[0];
      return a;
   endfunction

   // Holds the sender back until every item has been taken and answered.
   task automatic wait_all_home();
      while (items_taken != items_queued || predicted_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic program_select(input logic [CsrIdxW-1:0] idx, input logic [SelW-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (idx == CSR_LOW_SEL) sel_lo = val;
      else                    sel_hi = val;
   endtask

   // -------------------------------------------------------------------------
   // Driver: one item from the pending queue whenever the slot is free, with
   // the odd short gap after an item unless the run is in its steady part.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (access_q.size() != 0) begin
            req_data  <= access_q.pop_front();
            req_valid <= 1'b1;
            if (!steady && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: predicts on every accepted item, then checks any result taken
   // at the same edge, so a fast core cannot race its own expectation.
   // The result side stalls in short random bursts.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         clear_mapper();
         predicted_results.delete();
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_results.push_back(map_access(req_data));
            items_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               note_fault($sformatf("result %0d arrived with nothing expected",
                                    results_seen));
            end else begin
               want_rsp = predicted_results.pop_front();
               check_field("bank",         rsp_data.bank,         want_rsp.bank);
               check_field("wram_enabled", 9'(rsp_data.wram_enabled),
                           9'(want_rsp.wram_enabled));
               check_field("open_bus",     9'(rsp_data.open_bus),
                           9'(want_rsp.open_bus));
               check_field("mirroring",    9'(rsp_data.mirroring),
                           9'(want_rsp.mirroring));
               check_field("irq",          9'(rsp_data.irq),          9'(want_rsp.irq));
            end
            results_seen++;
         end
         if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (!steady && $urandom_range(0, 9) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_ready  <= 1'b1;
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles == WATCHDOG_LIMIT) begin
         $display("** bank_switch_mapper_with_irq_counter_core: FAILED **");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer: directed items under the reset select bits, then one set of
   // random traffic per select-bit setting. The select bits are changed only
   // once every result of the previous set has come back.
   // -------------------------------------------------------------------------
   initial begin
      int          target;
      int          burst;
      logic [7:0]  mode_byte;
      logic [2:0]  grp;
      logic [1:0]  idx;
      logic [SelW-1:0] lo_pick;
      logic [SelW-1:0] hi_pick;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: a tick with the counter off, every PRG slot below
      // 0x8000 (A15 ignored), CHR with high address bits set, open bus at
      // both ends, bank and control writes, the spare opcodes, an IRQ that
      // fires on the first cycle-mode tick, acknowledge and a sound write.
      queue_access(OP_TICK, 16'hFFFF, 8'hFF);
      queue_access(OP_PRG,  16'h0000, 8'h00);
      queue_access(OP_PRG,  16'h2000, 8'h00);
      queue_access(OP_PRG,  16'h5FFF, 8'h00);
      queue_access(OP_PRG,  16'h7FFF, 8'h00);
      queue_access(OP_CHR,  16'h0000, 8'h00);
      queue_access(OP_CHR,  16'hFFFF, 8'h00);
      queue_access(OP_WRAM, 16'h0000, 8'h00);
      queue_access(OP_WRITE, reg_addr(GRP_CTRL, IDX_CTRL), 8'hFF);
      queue_access(OP_WRAM, 16'hFFFF, 8'h00);
      queue_access(OP_WRITE, reg_addr(GRP_PRG0, 2'($urandom)), 8'hFF);
      queue_access(OP_WRITE, reg_addr(GRP_PRG1, 2'($urandom)), 8'h00);
      queue_access(OP_PRG,  16'hA000, 8'h00);
      queue_access(OP_PRG,  16'hFFFF, 8'h00);
      queue_access(OP_WRITE, reg_addr(GRP_CHR1, IDX_CTRL), 8'hFF);
      queue_access(OP_CHR,  16'h1C00, 8'h00);
      for (int o = int'(OP_WRAM) + 1; o < 8; o++) begin
         queue_access(3'(o), 16'($urandom), 8'($urandom));
      end
      queue_access(OP_WRITE, reg_addr(GRP_IRQ, IDX_RELOAD), 8'hFF);
      mode_byte = '0;
      mode_byte[MODE_ENABLE] = 1'b1;
      mode_byte[MODE_CYCLE]  = 1'b1;
      queue_access(OP_WRITE, reg_addr(GRP_IRQ, IDX_MODE), mode_byte);
      queue_access(OP_TICK, 16'h0000, 8'h00);
      queue_access(OP_WRITE, reg_addr(GRP_IRQ, IDX_ACK), 8'h00);
      queue_access(OP_TICK, 16'h0000, 8'h00);
      queue_access(OP_WRITE, reg_addr(GRP_SND0, 2'($urandom)), 8'($urandom));

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            // Settings: both select bits equal and at the top, both inside
            // the group field, a random pair, then the reversed extremes.
            case (phase)
               1: begin lo_pick = 4'd15; hi_pick = 4'd15; end
               2: begin lo_pick = 4'd12; hi_pick = 4'd14; end
               3: begin lo_pick = 4'($urandom); hi_pick = 4'($urandom); end
               default: begin lo_pick = 4'd15; hi_pick = 4'd0; end
            endcase
            wait_all_home();
            repeat (4) @(negedge clock);
            program_select(CSR_LOW_SEL, lo_pick);
            program_select(CSR_HIGH_SEL, hi_pick);
            @(negedge clock);
         end
         // The last set runs with both sides always willing.
         if (phase == PHASES - 1) steady = 1'b1;

         target = items_queued + ITEMS_PER_SET;
         while (items_queued < target) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  // Arm the counter, mostly with a latch close to overflow,
                  // then tick it long enough for it to fire.
                  queue_access(OP_WRITE, reg_addr(GRP_IRQ, IDX_RELOAD),
                               ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(8'hF0, 8'hFF)));
                  mode_byte = 8'($urandom);
                  if ($urandom_range(0, 4) != 0) mode_byte[MODE_ENABLE] = 1'b1;
                  queue_access(OP_WRITE, reg_addr(GRP_IRQ, IDX_MODE), mode_byte);
                  burst = mode_byte[MODE_CYCLE] ? $urandom_range(2, 40)
                                                : $urandom_range(20, 250);
                  for (int k = 0; k < burst; k++) begin
                     if ($urandom_range(0, 15) == 0)
                        queue_access(OP_PRG + 3'($urandom_range(0, 2)), 16'($urandom),
                                     8'($urandom));
                     else
                        queue_access(OP_TICK, 16'($urandom), 8'($urandom));
                  end
                  if ($urandom_range(0, 1) == 0)
                     queue_access(OP_WRITE, reg_addr(GRP_IRQ, IDX_ACK), 8'($urandom));
               end
               2, 3, 4: begin
                  // A bank or control write followed by lookups that see it.
                  case ($urandom_range(0, 4))
                     0: grp = GRP_PRG0;
                     1: grp = GRP_PRG1;
                     2: grp = GRP_CTRL;
                     3: grp = GRP_CHR0;
                     default: grp = GRP_CHR1;
                  endcase
                  idx = (grp == GRP_CTRL && $urandom_range(0, 1) == 0) ? IDX_CTRL
                                                                       : 2'($urandom);
                  queue_access(OP_WRITE, reg_addr(grp, idx), 8'($urandom));
                  burst = $urandom_range(1, 4);
                  for (int k = 0; k < burst; k++) begin
                     queue_access(OP_PRG + 3'($urandom_range(0, 2)), 16'($urandom),
                                  8'($urandom));
                  end
               end
               5, 6, 7: begin
                  queue_access(OP_TICK + 3'($urandom_range(0, 3)), 16'($urandom),
                               8'($urandom));
               end
               default: begin
                  // Noise: any opcode, spare ones included, any address.
                  queue_access(3'($urandom), 16'($urandom), 8'($urandom));
               end
            endcase
         end
      end

      wait_all_home();
      repeat (8) @(negedge clock);
      if (fault_count == 0 && predicted_results.size() == 0) begin
         $display("** bank_switch_mapper_with_irq_counter_core: PASSED **");
      end else begin
         $display("** bank_switch_mapper_with_irq_counter_core: FAILED **");
      end
      $finish;
   end

endmodule
